// File: design/rgd_pkg.sv
// ----------------------------------------------------------------------------
// rgd_pkg
// Shared types and constants of the RGB-to-gray ordered dither block: the
// configuration bundle, the mode codes, register indexes and the 8x8 Bayer
// threshold table.
// ----------------------------------------------------------------------------
package rgd_pkg;

  localparam logic [1:0] MODE_NBIT = 2'd0;
  localparam logic [1:0] MODE_TWO  = 2'd1;
  localparam logic [1:0] MODE_ONE  = 2'd2;

  localparam logic REG_DITHER_MODE    = 1'b0;
  localparam logic REG_BITS_PER_LEVEL = 1'b1;

  localparam logic [3:0] BITS_RESET = 4'd2;

  typedef struct packed {
    logic [1:0] dither_mode;
    logic [3:0] bits_per_level;
  } cfg_t;

  localparam logic [5:0] BAYER [64] = '{
    6'd0,  6'd32, 6'd12, 6'd44, 6'd2,  6'd34, 6'd14, 6'd46,
    6'd48, 6'd16, 6'd60, 6'd28, 6'd50, 6'd18, 6'd62, 6'd30,
    6'd8,  6'd40, 6'd4,  6'd36, 6'd10, 6'd42, 6'd6,  6'd38,
    6'd56, 6'd24, 6'd52, 6'd20, 6'd58, 6'd26, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd15, 6'd47, 6'd1,  6'd33, 6'd13, 6'd45,
    6'd51, 6'd19, 6'd63, 6'd31, 6'd49, 6'd17, 6'd61, 6'd29,
    6'd11, 6'd43, 6'd7,  6'd39, 6'd9,  6'd41, 6'd5,  6'd37,
    6'd59, 6'd27, 6'd55, 6'd23, 6'd57, 6'd25, 6'd53, 6'd21
  };

  // Threshold offset (entry - 1) with the bias of 32 already taken off.
  function automatic logic signed [6:0] bayer_offset(input logic [2:0] row,
                                                     input logic [2:0] col);
    logic [5:0] entry;
    entry = BAYER[{row, col}];
    return $signed({1'b0, entry}) - 7'sd33;
  endfunction

endpackage

// File: design/rgd_core.sv
// ----------------------------------------------------------------------------
// rgd_core
// Combinational gray conversion and ordered dither of one pixel.
// ----------------------------------------------------------------------------
module rgd_core (
  input  rgd_pkg::cfg_t cfg_i,
  input  logic [23:0]   pixel_rgb_i,
  input  logic [2:0]    col_phase_i,
  input  logic [2:0]    row_phase_i,
  output logic [7:0]    gray_level_o
);

  logic [7:0]         r, g, b;
  logic signed [6:0]  ofs;
  logic [3:0]         n;
  logic [2:0]         sh;
  logic [8:0]         white;
  logic [7:0]         mask;
  logic [9:0]         sum_w;
  logic [7:0]         gray_w;
  logic [15:0]        scaled;
  logic signed [15:0] v_w;
  logic signed [15:0] q_w;
  logic [7:0]         res_nbit;
  logic [9:0]         sum_e;
  logic [16:0]        prod_e;
  logic [7:0]         gray_e;
  logic signed [9:0]  v_e;
  logic               two;
  logic [7:0]         lo, hi;
  logic [1:0]         top;
  logic [1:0]         res_lvl;

  assign r   = pixel_rgb_i[23:16];
  assign g   = pixel_rgb_i[15:8];
  assign b   = pixel_rgb_i[7:0];
  assign ofs = rgd_pkg::bayer_offset(row_phase_i, col_phase_i);

  // N-bit path.
  always_comb begin
    if (cfg_i.bits_per_level < 4'd2) begin
      n = 4'd2;
    end else if (cfg_i.bits_per_level > 4'd8) begin
      n = 4'd8;
    end else begin
      n = cfg_i.bits_per_level;
    end
    sh     = 3'(n - 4'd2);
    white  = 9'((9'd1 << n) - 9'd1);
    mask   = 8'(8'hFF << (4'd8 - n));
    sum_w  = {2'b0, r} + {1'b0, g, 1'b0} + {2'b0, b};
    gray_w = sum_w[9:2];
    scaled = {8'b0, gray_w} << sh;
    v_w    = $signed(scaled) + {{9{ofs[6]}}, ofs};
    // Arithmetic shift gives the floor, as the rounding requires.
    q_w    = v_w >>> sh;
    if ({1'b0, gray_w} < white) begin
      res_nbit = 8'd0;
    end else if ({1'b0, gray_w} >= 9'd255 - white) begin
      res_nbit = mask;
    end else if (q_w < 16'sd0) begin
      res_nbit = 8'd0;
    end else if (q_w > 16'sd255) begin
      res_nbit = mask;
    end else begin
      res_nbit = q_w[7:0] & mask;
    end
  end

  // Two-level and one-bit path: gray is the sum times 85/256.
  always_comb begin
    two    = (cfg_i.dither_mode == rgd_pkg::MODE_TWO);
    lo     = two ? 8'd5 : 8'd16;
    hi     = two ? 8'd250 : 8'd240;
    top    = two ? 2'd3 : 2'd1;
    sum_e  = {2'b0, r} + {2'b0, g} + {2'b0, b};
    prod_e = {7'b0, sum_e} * 17'd85;
    gray_e = prod_e[15:8];
    v_e    = $signed({2'b0, gray_e}) + {{3{ofs[6]}}, ofs};
    if (gray_e < lo) begin
      res_lvl = 2'd0;
    end else if (gray_e >= hi) begin
      res_lvl = top;
    end else if (v_e < 10'sd5) begin
      res_lvl = 2'd0;
    end else if (v_e >= 10'sd250) begin
      res_lvl = top;
    end else if (two) begin
      res_lvl = v_e[7:6];
    end else begin
      res_lvl = {1'b0, v_e[7]};
    end
  end

  always_comb begin
    unique case (cfg_i.dither_mode)
      rgd_pkg::MODE_NBIT: gray_level_o = res_nbit;
      rgd_pkg::MODE_TWO,
      rgd_pkg::MODE_ONE:  gray_level_o = {6'b0, res_lvl};
      default:            gray_level_o = 8'd0;
    endcase
  end

endmodule

// File: design/rgb_gray_ordered_dither.sv
// ----------------------------------------------------------------------------
// rgb_gray_ordered_dither
// Stream block that turns RGB pixels into dithered gray with an 8x8 Bayer
// matrix, configured over an APB-style register port.
// ----------------------------------------------------------------------------
// Each pixel word is captured in an input register, converted and dithered
// by a single pass of combinational logic, and held in an output register;
// a pixel therefore passes through the input and then the output register,
// and one pixel is taken in every cycle as long as the output side keeps up.
// The two registers form a small pipeline, so a new word is taken while a
// finished result still waits. Register 0 (address 0) selects the mode:
// N-bit gray in the top bits, a two-bit level, or a one-bit level; register 1
// (address 4) gives the number of gray bits for the N-bit mode. Registers
// should be changed only when no pixel is in flight.
module rgb_gray_ordered_dither (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // pixel_rgb[23:0], col_phase[26:24], row_phase[29:27]
  // Gray output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // gray_level[7:0]
);

  rgd_pkg::cfg_t cfg_q;
  logic          cfg_wr;

  logic          in_vld_q;
  logic [29:0]   in_data_q;
  logic          out_vld_q;
  logic [7:0]    out_data_q;
  logic          out_ready;
  logic [7:0]    gray_level;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dither_mode    <= rgd_pkg::MODE_NBIT;
      cfg_q.bits_per_level <= rgd_pkg::BITS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rgd_pkg::REG_DITHER_MODE:    cfg_q.dither_mode    <= pwdata[1:0];
        rgd_pkg::REG_BITS_PER_LEVEL: cfg_q.bits_per_level <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rgd_pkg::REG_DITHER_MODE:    prdata = {30'b0, cfg_q.dither_mode};
      rgd_pkg::REG_BITS_PER_LEVEL: prdata = {28'b0, cfg_q.bits_per_level};
      default:                     prdata = 32'b0;
    endcase
  end

  // Two-register pipeline: each stage moves when the next one is free.
  assign out_ready     = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata[29:0];
    end
    if (in_vld_q && out_ready) begin
      out_data_q <= gray_level;
    end
  end

  rgd_core u_core (
    .cfg_i        (cfg_q),
    .pixel_rgb_i  (in_data_q[23:0]),
    .col_phase_i  (in_data_q[26:24]),
    .row_phase_i  (in_data_q[29:27]),
    .gray_level_o (gray_level)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // An accepted word always occupies the input stage in the next cycle.
  a_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> in_vld_q)
    else $error("accepted word did not reach the input stage");

  // A word blocked in the input stage keeps its contents.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_ready |=> in_vld_q && $stable(in_data_q))
    else $error("blocked input stage lost its word");

  // A word leaving the input stage shows up as a result.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_ready |=> out_vld_q)
    else $error("input stage word did not reach the output register");

  // With the output register empty the block must take input.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

endmodule
